/* design/hsc_pkg.sv */
`timescale 1ns / 1ps

package hsc_pkg;

    // Number of information bits that the code protects.
    localparam int DATA_BITS = 32;

    // Widths of the request and response fields.
    localparam int WORD_W  = 32;
    localparam int CHECK_W = 6;
    localparam int POS_W   = 6;

    // Command codes.
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Check bits: ceil(log2(DATA_BITS)) + 1.
    function automatic int calc_check_bits();
        int r;
        r = 0;
        for (int k = 0; k < 16; k++) begin
            if ((1 << r) < DATA_BITS) begin
                r = r + 1;
            end
        end
        return r + 1;
    endfunction

    localparam int CHECK_BITS = calc_check_bits();

    typedef logic [CHECK_BITS-1:0] t_col;
    typedef t_col t_col_arr [DATA_BITS];

    // Data column j is the j-th value, ascending, with two or more ones.
    // Columns that cannot be filled stay zero.
    function automatic t_col_arr build_cols();
        t_col_arr c;
        int       j;
        int       ones;
        for (int k = 0; k < DATA_BITS; k++) begin
            c[k] = '0;
        end
        j = 0;
        for (int v = 1; v < (1 << CHECK_BITS); v++) begin
            ones = 0;
            for (int b = 0; b < CHECK_BITS; b++) begin
                ones = ones + ((v >> b) & 1);
            end
            if (ones >= 2 && j < DATA_BITS) begin
                c[j] = CHECK_BITS'(v);
                j = j + 1;
            end
        end
        return c;
    endfunction

    localparam t_col_arr DATA_COLS = build_cols();

    // One request.
    typedef struct packed {
        logic               command;
        logic [WORD_W-1:0]  data_word;
        logic [CHECK_W-1:0] check_in;
    } t_req;

    // One response.
    typedef struct packed {
        logic [WORD_W-1:0]  data_out;
        logic [CHECK_W-1:0] check_out;
        logic [CHECK_W-1:0] syndrome;
        logic               error_detected;
        logic               corrected;
        logic               uncorrectable;
        logic [POS_W-1:0]   flip_position;
    } t_rsp;

endpackage

/* design/systematic_hamming_sec_codec.sv */
`timescale 1ns / 1ps

// Systematic Hamming single-error-correcting codec. A request (encode or
// decode) is taken whenever start is high; busy never rises, so one request
// is taken every cycle. Each response appears on o_rsp, marked by o_done
// for exactly one cycle, after passing the input register and then the
// parity and syndrome XOR trees into the response register.
// The receiver cannot stall, so it must take each response in the cycle it
// is shown. Encode returns the check bits; decode returns the syndrome and
// corrects a single flipped data or check bit, or flags the word as
// uncorrectable when the syndrome matches no column.
module systematic_hamming_sec_codec (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  hsc_pkg::t_req i_req,
    output logic          o_done,
    output hsc_pkg::t_rsp o_rsp
);
    import hsc_pkg::*;

    logic r_in_valid;
    t_req r_req;
    logic r_done;
    t_rsp r_rsp;
    t_rsp n_rsp;

    // The datapath takes a new request every cycle.
    assign busy = 1'b0;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    // Encode and decode logic.
    hsc_core u_core (
        .i_req (r_req),
        .o_rsp (n_rsp)
    );

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef SYNTHESIS
    // A taken request raises o_done via the input and response registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("response missing two cycles after a request");

    // A corrected word is never also uncorrectable.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_rsp.corrected && o_rsp.uncorrectable))
        else $error("corrected and uncorrectable both set");

    // Error flag agrees with the syndrome, and a nonzero syndrome is resolved.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.error_detected == (o_rsp.syndrome != '0)) &&
                   (o_rsp.error_detected == (o_rsp.corrected || o_rsp.uncorrectable)))
        else $error("error flags disagree with syndrome");

    // Without a correction the flip position reads zero.
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.corrected) |-> (o_rsp.flip_position == '0))
        else $error("flip position set without a correction");
`endif

endmodule

/* design/hsc_core.sv */
`timescale 1ns / 1ps

module hsc_core (
    input  hsc_pkg::t_req i_req,
    output hsc_pkg::t_rsp o_rsp
);
    import hsc_pkg::*;

    logic [DATA_BITS-1:0]  data;
    logic [CHECK_BITS-1:0] chk_in;
    logic [CHECK_BITS-1:0] calc;
    logic [CHECK_BITS-1:0] syn;
    logic [DATA_BITS-1:0]  data_hit;
    logic [CHECK_BITS-1:0] check_hit;
    logic [POS_W-1:0]      pos;
    logic                  decode;
    logic                  hit;

    // Bits above the code's width are ignored.
    assign data   = DATA_BITS'(i_req.data_word);
    assign chk_in = CHECK_BITS'(i_req.check_in);
    assign decode = (i_req.command == CMD_DECODE);

    // Parity: XOR of the columns of all set data bits.
    always_comb begin
        calc = '0;
        for (int j = 0; j < DATA_BITS; j++) begin
            if (data[j]) begin
                calc = calc ^ DATA_COLS[j];
            end
        end
    end

    assign syn = decode ? (calc ^ chk_in) : '0;

    // Match the syndrome against every column. Data columns are distinct and
    // have two or more ones, so at most one column can match.
    always_comb begin
        for (int j = 0; j < DATA_BITS; j++) begin
            data_hit[j] = (syn != '0) && (DATA_COLS[j] == syn);
        end
        for (int i = 0; i < CHECK_BITS; i++) begin
            check_hit[i] = (syn == (CHECK_BITS'(1) << (CHECK_BITS - 1 - i)));
        end
    end

    assign hit = (|data_hit) || (|check_hit);

    // Position of the matching column; zero when nothing matches.
    always_comb begin
        pos = '0;
        for (int j = 0; j < DATA_BITS; j++) begin
            if (data_hit[j]) begin
                pos = pos | POS_W'(j);
            end
        end
        for (int i = 0; i < CHECK_BITS; i++) begin
            if (check_hit[i]) begin
                pos = pos | POS_W'(DATA_BITS + i);
            end
        end
    end

    // Assemble the response.
    always_comb begin
        o_rsp.data_out       = WORD_W'(data ^ data_hit);
        o_rsp.check_out      = decode ? CHECK_W'(chk_in ^ syn & {CHECK_BITS{|check_hit}})
                                      : CHECK_W'(calc);
        o_rsp.syndrome       = CHECK_W'(syn);
        o_rsp.error_detected = (syn != '0);
        o_rsp.corrected      = hit;
        o_rsp.uncorrectable  = (syn != '0) && !hit;
        o_rsp.flip_position  = pos;
    end

endmodule
